// File: sv/memory_range_hazard_tracker_core_macros.svh
// Assertion macros for the memory range hazard tracker.
// Used by the port-level checker; needs clk and arst_n in scope.
`ifndef MEMORY_RANGE_HAZARD_TRACKER_CORE_MACROS_SVH
`define MEMORY_RANGE_HAZARD_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define MRHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mrht_pkg.sv
// Package for the memory range hazard tracker: sizes, codes, range entry type.
// No dependencies.
package mrht_pkg;

	localparam int TABLE_DEPTH    = 16;
	localparam int ADDR_BITS      = 48;
	localparam int BUFFER_ID_BITS = 16;
	localparam int IDX_W          = $clog2(TABLE_DEPTH);
	localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
	localparam logic [15:0] MAX_OPS_RESET = 16'd32;
	localparam logic [15:0] OPS_SAT       = 16'hFFFF;

	localparam logic [2:0] OP_CHECK  = 3'd0;
	localparam logic [2:0] OP_COMMIT = 3'd1;
	localparam logic [2:0] OP_END    = 3'd2;
	localparam logic [2:0] OP_BEGIN  = 3'd3;
	localparam logic [2:0] OP_SYNC   = 3'd4;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_BARRIER = 2'd1;
	localparam logic [1:0] ACT_SUBMIT  = 2'd2;

	localparam logic [1:0] CFG_DEFERRED = 2'd0;
	localparam logic [1:0] CFG_SOH      = 2'd1;
	localparam logic [1:0] CFG_MAX_OPS  = 2'd2;

	typedef struct packed {
		logic [BUFFER_ID_BITS-1:0] buf_id;
		logic [ADDR_BITS-1:0]      lo;
		logic [ADDR_BITS-1:0]      hi;
	} span_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		span_t            data;
	} tbl_wr_t;

endpackage

// File: sv/mrht_table.sv
// Range table storage: one write port, one registered read port.
// Depends on mrht_pkg.
module mrht_table import mrht_pkg::*; (
	input  logic             clk,
	input  tbl_wr_t          wr,
	input  logic [IDX_W-1:0] raddr,
	output span_t            rdata_q
);

	span_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// File: sv/mrht_overlap.sv
// Shared overlap comparator: same buffer and intersecting byte ranges.
// Depends on mrht_pkg.
module mrht_overlap import mrht_pkg::*; (
	input  span_t req,
	input  span_t entry,
	output logic  hit
);

	assign hit = (req.buf_id == entry.buf_id) && (req.lo < entry.hi) && (entry.lo < req.hi);

endmodule

// File: sv/memory_range_hazard_tracker_core.sv
// Memory range hazard tracker, top level: sequencer, registers, result port.
// Depends on mrht_pkg, mrht_table, mrht_overlap.
// done strobes from a register after the response state. A tracked non-empty check first walks
// the write table and, for a write, then the read table, before the response state.
// One item at a time; the next start is taken in the cycle done is shown.
// Reset clears counts, batch state and config registers to their defaults; tables are not cleared.
module memory_range_hazard_tracker_core import mrht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [15:0] buffer_id,
	input  logic [47:0] range_begin,
	input  logic [47:0] range_end,
	input  logic        is_write,
	input  logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [1:0]  action,
	output logic        hazard,
	output logic        table_overflow,
	output logic        batch_open
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t           state_q;
	logic [2:0]       op_q;
	span_t            span_q;
	logic             wr_q;
	logic             last_q;
	logic             sel_q;
	logic             sel_s1;
	logic             pend_s1;
	logic [CNT_W-1:0] idx_q;
	logic             hit_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [CNT_W-1:0] wcnt_q;
	logic             rec_q;
	logic [15:0]      opc_q;
	logic             hseen_q;
	logic             deferred_q;
	logic             soh_q;
	logic [15:0]      maxops_q;
	logic             done_q;
	logic [1:0]       action_q;
	logic             hazard_q;
	logic             ovf_q;

	span_t            in_span;
	logic             accept;
	logic             scan_go;
	logic [CNT_W-1:0] cnt_sel;
	logic             issue;
	span_t            wt_rdata;
	span_t            rt_rdata;
	span_t            entry;
	logic             hit_c;
	tbl_wr_t          wt_wr;
	tbl_wr_t          rt_wr;

	logic             tracking;
	logic             empty;
	logic             hs_new;
	logic             full;
	logic [CNT_W-1:0] cnt_cur;
	logic [15:0]      opc_inc;
	logic [CNT_W-1:0] n_rcnt;
	logic [CNT_W-1:0] n_wcnt;
	logic             n_rec;
	logic [15:0]      n_opc;
	logic             n_hs;
	logic [1:0]       r_act;
	logic             r_hz;
	logic             r_ovf;
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_addr;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	assign in_span.buf_id = BUFFER_ID_BITS'(buffer_id);
	assign in_span.lo     = ADDR_BITS'(range_begin);
	assign in_span.hi     = ADDR_BITS'(range_end);
	assign scan_go = (operation == OP_CHECK) && deferred_q && rec_q
		&& (in_span.lo < in_span.hi);

	assign cnt_sel = sel_q ? rcnt_q : wcnt_q;
	assign issue   = (state_q == ST_SCAN) && (idx_q < cnt_sel);

	mrht_table u_wtab (
		.clk     (clk),
		.wr      (wt_wr),
		.raddr   (idx_q[IDX_W-1:0]),
		.rdata_q (wt_rdata)
	);

	mrht_table u_rtab (
		.clk     (clk),
		.wr      (rt_wr),
		.raddr   (idx_q[IDX_W-1:0]),
		.rdata_q (rt_rdata)
	);

	assign entry = sel_s1 ? rt_rdata : wt_rdata;

	mrht_overlap u_cmp (
		.req   (span_q),
		.entry (entry),
		.hit   (hit_c)
	);

	// response decode
	assign tracking = deferred_q && rec_q;
	assign empty    = (span_q.hi <= span_q.lo);
	assign hs_new   = hseen_q || hit_q;
	assign cnt_cur  = wr_q ? wcnt_q : rcnt_q;
	assign full     = (cnt_cur >= CNT_W'(TABLE_DEPTH));
	assign opc_inc  = (opc_q < OPS_SAT) ? (opc_q + 16'd1) : opc_q;
	assign tbl_addr = full ? '0 : cnt_cur[IDX_W-1:0];

	always_comb begin
		n_rcnt = rcnt_q;
		n_wcnt = wcnt_q;
		n_rec  = rec_q;
		n_opc  = opc_q;
		n_hs   = hseen_q;
		r_act  = ACT_NONE;
		r_hz   = 1'b0;
		r_ovf  = 1'b0;
		tbl_we = 1'b0;
		unique case (op_q)
			OP_CHECK: begin
				if (!tracking) begin
					if (last_q) begin
						n_hs = 1'b0;
					end
				end else begin
					r_hz = hs_new;
					n_hs = hs_new;
					if (last_q) begin
						n_hs = 1'b0;
						if (hs_new) begin
							n_rcnt = '0;
							n_wcnt = '0;
							if (soh_q && (opc_q != 16'd0)) begin
								r_act = ACT_SUBMIT;
								n_opc = 16'd0;
								n_rec = 1'b0;
							end else begin
								r_act = ACT_BARRIER;
							end
						end
					end
				end
			end
			OP_COMMIT: begin
				if (tracking && !empty) begin
					tbl_we = 1'b1;
					if (full) begin
						r_act  = ACT_BARRIER;
						r_ovf  = 1'b1;
						n_rcnt = '0;
						n_wcnt = '0;
					end
					if (wr_q) begin
						n_wcnt = full ? CNT_W'(1) : (wcnt_q + CNT_W'(1));
					end else begin
						n_rcnt = full ? CNT_W'(1) : (rcnt_q + CNT_W'(1));
					end
				end
			end
			OP_END: begin
				if (rec_q) begin
					if (!deferred_q || (opc_inc >= maxops_q)) begin
						r_act  = ACT_SUBMIT;
						n_rcnt = '0;
						n_wcnt = '0;
						n_opc  = 16'd0;
						n_hs   = 1'b0;
						n_rec  = 1'b0;
					end else begin
						r_act = ACT_BARRIER;
						n_opc = opc_inc;
					end
				end
			end
			OP_BEGIN: begin
				if (!rec_q) begin
					n_rcnt = '0;
					n_wcnt = '0;
					n_opc  = 16'd0;
					n_hs   = 1'b0;
					n_rec  = 1'b1;
				end
			end
			OP_SYNC: begin
				r_act  = rec_q ? ACT_SUBMIT : ACT_NONE;
				n_rcnt = '0;
				n_wcnt = '0;
				n_opc  = 16'd0;
				n_hs   = 1'b0;
				n_rec  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wt_wr.we   = (state_q == ST_RESP) && tbl_we && wr_q;
	assign wt_wr.addr = tbl_addr;
	assign wt_wr.data = span_q;
	assign rt_wr.we   = (state_q == ST_RESP) && tbl_we && !wr_q;
	assign rt_wr.addr = tbl_addr;
	assign rt_wr.data = span_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			span_q <= in_span;
			wr_q   <= is_write;
			last_q <= last;
		end
		if (state_q == ST_RESP) begin
			action_q <= r_act;
			hazard_q <= r_hz;
			ovf_q    <= r_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sel_q      <= 1'b0;
			sel_s1     <= 1'b0;
			pend_s1    <= 1'b0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			rcnt_q     <= '0;
			wcnt_q     <= '0;
			rec_q      <= 1'b0;
			opc_q      <= 16'd0;
			hseen_q    <= 1'b0;
			deferred_q <= 1'b1;
			soh_q      <= 1'b0;
			maxops_q   <= MAX_OPS_RESET;
			done_q     <= 1'b0;
		end else begin
			done_q  <= (state_q == ST_RESP);
			pend_s1 <= issue;
			sel_s1  <= sel_q;
			if (accept) begin
				hit_q <= 1'b0;
			end else if (pend_s1 && hit_c) begin
				hit_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_DEFERRED: deferred_q <= cfg_data[0];
					CFG_SOH:      soh_q      <= cfg_data[0];
					CFG_MAX_OPS:  maxops_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sel_q   <= 1'b0;
						idx_q   <= '0;
						state_q <= scan_go ? ST_SCAN : ST_RESP;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!sel_q && wr_q) begin
						sel_q <= 1'b1;
						idx_q <= '0;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					rcnt_q  <= n_rcnt;
					wcnt_q  <= n_wcnt;
					rec_q   <= n_rec;
					opc_q   <= n_opc;
					hseen_q <= n_hs;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign action         = action_q;
	assign hazard         = hazard_q;
	assign table_overflow = ovf_q;
	assign batch_open     = rec_q;

endmodule

// File: sv/mrht_checker.sv
// Port-level checker for the memory range hazard tracker, bound to the top level.
// Depends on mrht_pkg and memory_range_hazard_tracker_core_macros.svh.
`include "memory_range_hazard_tracker_core_macros.svh"

module mrht_checker import mrht_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] action,
	input logic       table_overflow,
	input logic       batch_open
);

	`MRHT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`MRHT_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a request in flight")
	`MRHT_ASSERT_IMP(a_action_code, done, action <= ACT_SUBMIT, "undefined action code")
	`MRHT_ASSERT_IMP(a_submit_closes, done && (action == ACT_SUBMIT), !batch_open, "submit left batch open")
	`MRHT_ASSERT_IMP(a_ovf_barrier, done && table_overflow, action == ACT_BARRIER, "overflow without barrier")

endmodule

bind memory_range_hazard_tracker_core mrht_checker u_mrht_checker (.*);
